// ===== rtl/midi_note_balance_tracker_top_defines.svh =====
// Assertion macros for the MIDI note balance tracker checker.
// Depends on nothing; included by the checker file only.
`ifndef MIDI_NOTE_BALANCE_TRACKER_TOP_DEFINES_SVH
`define MIDI_NOTE_BALANCE_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MNBT_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("mnbt: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define MNBT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("mnbt: next-cycle check failed");

`endif

// ===== rtl/mnbt_pkg.sv =====
// Shared types and constants for the MIDI note balance tracker.
// No dependencies; used by the interfaces, front, back and top level.
`timescale 1ns / 1ps

package mnbt_pkg;

	localparam int OP_W       = 2;
	localparam int CH_W       = 4;
	localparam int KEY_W      = 8;
	localparam int VEL_W      = 8;
	localparam int CTRL_W     = 7;
	localparam int COUNT_W    = 8;
	localparam int SOUNDING_W = 19;
	localparam int TALLY_W    = 32;
	localparam int HELD_W     = 12;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [KEY_W-1:0]  KEY_MAX            = 8'd127;
	localparam logic [CTRL_W-1:0] SOUND_OFF_DEFAULT  = 7'd120;
	localparam logic [CTRL_W-1:0] NOTES_OFF_DEFAULT  = 7'd123;

	// register index, taken from paddr[2]
	localparam logic REG_SOUND_OFF = 1'b0;
	localparam logic REG_NOTES_OFF = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_NOTE_OFF = 2'd0,
		OP_NOTE_ON  = 2'd1,
		OP_CTRL     = 2'd2,
		OP_QUERY    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_ON    = 2'd1,
		KIND_OFF   = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic              ch_ok;
		logic              key_ok;
		logic [CH_W-1:0]   ch;
		logic [KEY_W-1:0]  key;
	} cmd_t;

endpackage

// ===== rtl/mnbt_ifs.sv =====
// Valid/ready channel interfaces for event and result beats.
// Depends on mnbt_pkg for field widths.
`timescale 1ns / 1ps

interface mnbt_evt_if;
	logic                          valid;
	logic                          ready;
	logic [mnbt_pkg::OP_W-1:0]     op;
	logic [mnbt_pkg::CH_W-1:0]     midi_channel;
	logic [mnbt_pkg::KEY_W-1:0]    key_or_controller;
	logic [mnbt_pkg::VEL_W-1:0]    velocity_or_value;

	modport source (output valid, op, midi_channel, key_or_controller, velocity_or_value,
		input ready);
	modport sink (input valid, op, midi_channel, key_or_controller, velocity_or_value,
		output ready);
endinterface

interface mnbt_res_if;
	logic                              valid;
	logic                              ready;
	logic                              queried_note_held;
	logic [mnbt_pkg::COUNT_W-1:0]      queried_note_count;
	logic [mnbt_pkg::SOUNDING_W-1:0]   notes_sounding;
	logic [mnbt_pkg::SOUNDING_W-1:0]   peak_sounding;
	logic [mnbt_pkg::TALLY_W-1:0]      note_on_tally;
	logic [mnbt_pkg::TALLY_W-1:0]      note_off_tally;
	logic [mnbt_pkg::TALLY_W-1:0]      unmatched_off_tally;
	logic [mnbt_pkg::HELD_W-1:0]       held_keys;

	modport source (output valid, queried_note_held, queried_note_count, notes_sounding,
		peak_sounding, note_on_tally, note_off_tally, unmatched_off_tally, held_keys,
		input ready);
	modport sink (input valid, queried_note_held, queried_note_count, notes_sounding,
		peak_sounding, note_on_tally, note_off_tally, unmatched_off_tally, held_keys,
		output ready);
endinterface

// ===== rtl/mnbt_front.sv =====
// Front end: accepts event beats, classifies them and queues commands.
// Depends on mnbt_pkg and mnbt_evt_if.
`timescale 1ns / 1ps

module mnbt_front #(
	parameter int NUM_CHANNELS = 16,
	parameter int NUM_KEYS     = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	mnbt_evt_if.sink                        evt,
	input  logic [mnbt_pkg::CTRL_W-1:0]     sound_off_ctrl,
	input  logic [mnbt_pkg::CTRL_W-1:0]     notes_off_ctrl,
	output mnbt_pkg::cmd_t                  cmd,
	output logic                            cmd_valid,
	input  logic                            cmd_pop
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	mnbt_pkg::cmd_t     fifo_q [DEPTH];
	mnbt_pkg::cmd_t     cls;
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               ch_ok;
	logic               key_ok;
	logic               ctrl_hit;

	assign ch_ok  = {1'b0, evt.midi_channel} < (mnbt_pkg::CH_W + 1)'(NUM_CHANNELS);
	assign key_ok = (evt.key_or_controller <= mnbt_pkg::KEY_MAX) &&
		({1'b0, evt.key_or_controller} < (mnbt_pkg::KEY_W + 1)'(NUM_KEYS));
	assign ctrl_hit = (evt.key_or_controller == {1'b0, sound_off_ctrl}) ||
		(evt.key_or_controller == {1'b0, notes_off_ctrl});

	always_comb begin
		cls.ch_ok  = ch_ok;
		cls.key_ok = key_ok;
		cls.ch     = evt.midi_channel;
		cls.key    = evt.key_or_controller;
		cls.kind   = mnbt_pkg::KIND_READ;
		unique case (mnbt_pkg::op_t'(evt.op))
			mnbt_pkg::OP_NOTE_OFF: begin
				if (ch_ok && key_ok)
					cls.kind = mnbt_pkg::KIND_OFF;
			end
			mnbt_pkg::OP_NOTE_ON: begin
				if (ch_ok && key_ok)
					cls.kind = (evt.velocity_or_value != '0) ? mnbt_pkg::KIND_ON
						: mnbt_pkg::KIND_OFF;
			end
			mnbt_pkg::OP_CTRL: begin
				if (ch_ok && ctrl_hit)
					cls.kind = mnbt_pkg::KIND_CLEAR;
			end
			mnbt_pkg::OP_QUERY: begin
				cls.kind = mnbt_pkg::KIND_READ;
			end
			default: begin
				cls.kind = mnbt_pkg::KIND_READ;
			end
		endcase
	end

	assign evt.ready = (count_q != CNT_W'(DEPTH));
	assign push      = evt.valid && evt.ready;
	assign cmd_valid = (count_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (cmd_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !cmd_pop)
				count_q <= count_q + 1'b1;
			else if (!push && cmd_pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/mnbt_back.sv =====
// Back end: counter memory read-modify-write, totals, tallies and result register.
// Depends on mnbt_pkg and mnbt_res_if.
`timescale 1ns / 1ps

module mnbt_back #(
	parameter int NUM_CHANNELS = 16,
	parameter int NUM_KEYS     = 128,
	parameter int COUNTER_BITS = 8,
	parameter int TALLY_BITS   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mnbt_pkg::cmd_t    cmd,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	mnbt_res_if.source        res
);

	localparam int CW       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int KW       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int ADDR_W   = CW + KW;
	localparam int DEPTH    = 1 << ADDR_W;
	localparam int CNT_MAXV = (1 << COUNTER_BITS) - 1;
	localparam int CHSUM_W  = $clog2(NUM_KEYS * CNT_MAXV + 1);
	localparam int CHHELD_W = $clog2(NUM_KEYS + 1);
	localparam int SUM_W    = $clog2(NUM_CHANNELS * NUM_KEYS * CNT_MAXV + 1);
	localparam int HELD_W   = $clog2(NUM_CHANNELS * NUM_KEYS + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t                    state_q;
	mnbt_pkg::cmd_t            cur_q;
	logic [COUNTER_BITS-1:0]   cnt_mem [DEPTH];
	logic [NUM_KEYS-1:0]       vld_mem [1 << CW];
	logic [COUNTER_BITS-1:0]   cnt_rd_q;
	logic [NUM_KEYS-1:0]       vrow_rd_q;

	logic                      row_ok_q [NUM_CHANNELS];
	logic [CHSUM_W-1:0]        chsum_q  [NUM_CHANNELS];
	logic [CHHELD_W-1:0]       chheld_q [NUM_CHANNELS];
	logic [SUM_W-1:0]          total_q;
	logic [SUM_W-1:0]          peak_q;
	logic [HELD_W-1:0]         held_q;
	logic [TALLY_BITS-1:0]     on_q;
	logic [TALLY_BITS-1:0]     off_q;
	logic [TALLY_BITS-1:0]     orphan_q;

	logic                      out_valid_q;
	logic                      out_held_q;
	logic [mnbt_pkg::COUNT_W-1:0]    out_cnt_q;
	logic [mnbt_pkg::SOUNDING_W-1:0] out_total_q;
	logic [mnbt_pkg::SOUNDING_W-1:0] out_peak_q;
	logic [mnbt_pkg::TALLY_W-1:0]    out_on_q;
	logic [mnbt_pkg::TALLY_W-1:0]    out_off_q;
	logic [mnbt_pkg::TALLY_W-1:0]    out_orphan_q;
	logic [mnbt_pkg::HELD_W-1:0]     out_keys_q;

	logic [CW-1:0]             rd_ch;
	logic [ADDR_W-1:0]         rd_addr;
	logic [CW-1:0]             chi;
	logic [KW-1:0]             keyi;
	logic [ADDR_W-1:0]         wr_addr;
	logic                      vbit;
	logic [COUNTER_BITS-1:0]   c;
	logic [COUNTER_BITS-1:0]   cnt_new;
	logic [COUNTER_BITS-1:0]   cnt_after;
	logic [NUM_KEYS-1:0]       vrow_new;
	logic                      wr_en;
	logic                      on_inc;
	logic                      off_inc;
	logic                      orphan_inc;
	logic                      clr;
	logic                      sum_inc;
	logic                      sum_dec;
	logic                      held_inc;
	logic                      held_dec;
	logic [SUM_W-1:0]          total_next;
	logic [SUM_W-1:0]          peak_next;
	logic [HELD_W-1:0]         held_next;
	logic                      commit;

	assign rd_ch   = cmd.ch[CW-1:0];
	assign rd_addr = {cmd.ch[CW-1:0], cmd.key[KW-1:0]};
	assign chi     = cur_q.ch[CW-1:0];
	assign keyi    = cur_q.key[KW-1:0];
	assign wr_addr = {chi, keyi};

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign commit  = (state_q == ST_EXEC) && (!out_valid_q || res.ready);

	// registered reads, one entry per item
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cnt_rd_q  <= cnt_mem[rd_addr];
			vrow_rd_q <= vld_mem[rd_ch];
			cur_q     <= cmd;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && wr_en) begin
			cnt_mem[wr_addr] <= cnt_new;
			vld_mem[chi]     <= vrow_new;
		end
	end

	always_comb begin
		vbit       = cur_q.ch_ok && cur_q.key_ok && row_ok_q[chi] && vrow_rd_q[keyi];
		c          = vbit ? cnt_rd_q : '0;
		cnt_new    = c;
		wr_en      = 1'b0;
		on_inc     = 1'b0;
		off_inc    = 1'b0;
		orphan_inc = 1'b0;
		clr        = 1'b0;
		sum_inc    = 1'b0;
		sum_dec    = 1'b0;
		held_inc   = 1'b0;
		held_dec   = 1'b0;
		unique case (cur_q.kind)
			mnbt_pkg::KIND_ON: begin
				on_inc = 1'b1;
				if (c != COUNTER_BITS'(CNT_MAXV)) begin
					wr_en    = 1'b1;
					cnt_new  = c + 1'b1;
					sum_inc  = 1'b1;
					held_inc = (c == '0);
				end
			end
			mnbt_pkg::KIND_OFF: begin
				off_inc = 1'b1;
				if (c != '0) begin
					wr_en    = 1'b1;
					cnt_new  = c - 1'b1;
					sum_dec  = 1'b1;
					held_dec = (c == COUNTER_BITS'(1));
				end else begin
					orphan_inc = 1'b1;
				end
			end
			mnbt_pkg::KIND_CLEAR: begin
				clr = 1'b1;
			end
			mnbt_pkg::KIND_READ: begin
				wr_en = 1'b0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		vrow_new       = row_ok_q[chi] ? vrow_rd_q : '0;
		vrow_new[keyi] = 1'b1;
	end

	always_comb begin
		if (clr)
			total_next = total_q - SUM_W'(chsum_q[chi]);
		else if (sum_inc)
			total_next = total_q + 1'b1;
		else if (sum_dec)
			total_next = total_q - 1'b1;
		else
			total_next = total_q;

		if (clr)
			held_next = held_q - HELD_W'(chheld_q[chi]);
		else if (held_inc)
			held_next = held_q + 1'b1;
		else if (held_dec)
			held_next = held_q - 1'b1;
		else
			held_next = held_q;

		peak_next = (total_next > peak_q) ? total_next : peak_q;
		cnt_after = clr ? '0 : (wr_en ? cnt_new : c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			total_q     <= '0;
			peak_q      <= '0;
			held_q      <= '0;
			on_q        <= '0;
			off_q       <= '0;
			orphan_q    <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				row_ok_q[i] <= 1'b0;
				chsum_q[i]  <= '0;
				chheld_q[i] <= '0;
			end
		end else begin
			if (commit)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (commit) begin
						state_q     <= ST_IDLE;
						total_q     <= total_next;
						peak_q      <= peak_next;
						held_q      <= held_next;
						if (on_inc)
							on_q <= on_q + 1'b1;
						if (off_inc)
							off_q <= off_q + 1'b1;
						if (orphan_inc)
							orphan_q <= orphan_q + 1'b1;
						if (clr) begin
							row_ok_q[chi] <= 1'b0;
							chsum_q[chi]  <= '0;
							chheld_q[chi] <= '0;
						end
						if (wr_en)
							row_ok_q[chi] <= 1'b1;
						if (sum_inc)
							chsum_q[chi] <= chsum_q[chi] + 1'b1;
						else if (sum_dec)
							chsum_q[chi] <= chsum_q[chi] - 1'b1;
						if (held_inc)
							chheld_q[chi] <= chheld_q[chi] + 1'b1;
						else if (held_dec)
							chheld_q[chi] <= chheld_q[chi] - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_held_q   <= (cnt_after != '0);
			out_cnt_q    <= mnbt_pkg::COUNT_W'(cnt_after);
			out_total_q  <= mnbt_pkg::SOUNDING_W'(total_next);
			out_peak_q   <= mnbt_pkg::SOUNDING_W'(peak_next);
			out_on_q     <= mnbt_pkg::TALLY_W'(on_inc ? on_q + 1'b1 : on_q);
			out_off_q    <= mnbt_pkg::TALLY_W'(off_inc ? off_q + 1'b1 : off_q);
			out_orphan_q <= mnbt_pkg::TALLY_W'(orphan_inc ? orphan_q + 1'b1 : orphan_q);
			out_keys_q   <= mnbt_pkg::HELD_W'(held_next);
		end
	end

	assign res.valid               = out_valid_q;
	assign res.queried_note_held   = out_held_q;
	assign res.queried_note_count  = out_cnt_q;
	assign res.notes_sounding      = out_total_q;
	assign res.peak_sounding       = out_peak_q;
	assign res.note_on_tally       = out_on_q;
	assign res.note_off_tally      = out_off_q;
	assign res.unmatched_off_tally = out_orphan_q;
	assign res.held_keys           = out_keys_q;

endmodule

// ===== rtl/midi_note_balance_tracker_top.sv =====
// An event beat passes the command queue, the counter read (ST_IDLE) and update (ST_EXEC),
// which loads the result register; no new command is taken until ST_EXEC commits.
// A two-entry command queue keeps the event side accepting while a result waits.
// Reset (arst_n, asynchronous): clears totals, tallies, queue and per-channel row flags;
// the counter memory itself is not cleared, row flags make unwritten entries read as zero.
`timescale 1ns / 1ps

module midi_note_balance_tracker_top #(
	parameter int NUM_CHANNELS = 16,
	parameter int NUM_KEYS     = 128,
	parameter int COUNTER_BITS = 8,
	parameter int TALLY_BITS   = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	mnbt_evt_if.sink                             evt,
	mnbt_res_if.source                           res,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [mnbt_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [mnbt_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [mnbt_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready
);

	logic [mnbt_pkg::CTRL_W-1:0] sound_off_q;
	logic [mnbt_pkg::CTRL_W-1:0] notes_off_q;
	logic                        cfg_wr;
	logic                        reg_idx;
	mnbt_pkg::cmd_t              cmd;
	logic                        cmd_valid;
	logic                        cmd_pop;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_off_q <= mnbt_pkg::SOUND_OFF_DEFAULT;
			notes_off_q <= mnbt_pkg::NOTES_OFF_DEFAULT;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				mnbt_pkg::REG_SOUND_OFF: sound_off_q <= pwdata[mnbt_pkg::CTRL_W-1:0];
				mnbt_pkg::REG_NOTES_OFF: notes_off_q <= pwdata[mnbt_pkg::CTRL_W-1:0];
				default: sound_off_q <= sound_off_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			mnbt_pkg::REG_SOUND_OFF: prdata = mnbt_pkg::APB_DATA_W'(sound_off_q);
			mnbt_pkg::REG_NOTES_OFF: prdata = mnbt_pkg::APB_DATA_W'(notes_off_q);
			default: prdata = '0;
		endcase
	end

	mnbt_front #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.NUM_KEYS     (NUM_KEYS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.evt            (evt),
		.sound_off_ctrl (sound_off_q),
		.notes_off_ctrl (notes_off_q),
		.cmd            (cmd),
		.cmd_valid      (cmd_valid),
		.cmd_pop        (cmd_pop)
	);

	mnbt_back #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.NUM_KEYS     (NUM_KEYS),
		.COUNTER_BITS (COUNTER_BITS),
		.TALLY_BITS   (TALLY_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.res       (res)
	);

endmodule

// ===== rtl/mnbt_checker.sv =====
// Port-level checks on the result channel of the tracker, bound to the top level.
// Depends on mnbt_pkg and midi_note_balance_tracker_top_defines.svh.
`timescale 1ns / 1ps
`include "midi_note_balance_tracker_top_defines.svh"

module mnbt_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                res_valid,
	input logic                                res_ready,
	input logic                                note_held,
	input logic [mnbt_pkg::COUNT_W-1:0]        note_count,
	input logic [mnbt_pkg::SOUNDING_W-1:0]     sounding,
	input logic [mnbt_pkg::SOUNDING_W-1:0]     peak,
	input logic [mnbt_pkg::HELD_W-1:0]         keys
);

	// a stalled result beat stays put
	`MNBT_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(sounding) && $stable(note_count))

	`MNBT_ASSERT_NOW(a_held_flag, clk, arst_n, res_valid, note_held == (note_count != '0))

	`MNBT_ASSERT_NOW(a_peak_above, clk, arst_n, res_valid, peak >= sounding)

	// every held key carries at least one sounding note
	`MNBT_ASSERT_NOW(a_keys_le_sum, clk, arst_n, res_valid, mnbt_pkg::SOUNDING_W'(keys) <= sounding)

endmodule

bind midi_note_balance_tracker_top mnbt_checker u_mnbt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.note_held  (res.queried_note_held),
	.note_count (res.queried_note_count),
	.sounding   (res.notes_sounding),
	.peak       (res.peak_sounding),
	.keys       (res.held_keys)
);
